>>> rtl/periodic_task_dispatcher_core_assert.svh
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_core_assert.svh
// Assertion macros for the periodic task dispatcher; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)

`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and constants shared by the periodic task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

    localparam int unsigned VAL_W     = 16;
    localparam int unsigned DIV_W     = VAL_W + 1;
    localparam int unsigned DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd17;
    localparam logic [VAL_W-1:0] WRAP_RESET = 16'd1000;
    localparam logic [VAL_W-1:0] OVR_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        K_DISPATCH = 3'd0,
        K_OVERRUN  = 3'd1,
        K_TICK_END = 3'd2,
        K_ADD_OK   = 3'd3,
        K_ADD_REJ  = 3'd4,
        K_FINISH   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [VAL_W-1:0] period;
        logic [VAL_W-1:0] offset;
        logic [VAL_W-1:0] overrun;
        logic             running;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_core
// Time-triggered cyclic executive: task table in one synchronous RAM.
// ----------------------------------------------------------------------------
// One word in at a time. Add and finish end with one result word. A tick
// advances the wrapping counter with the bit-serial remainder unit, then
// scans each task (one RAM read, a 17-step bit-serial remainder, a write-back
// when due), then emits the tick end word. Each result word waits while
// m_tready holds it back.
// tick_wrap is to be written over the cfg channel while the block is idle;
// the block itself does not enforce this, as cfg_ready is always high. A
// value of zero means 65536. Out-of-range or full-table adds are rejected.
`default_nettype none

module periodic_task_dispatcher_core #(
    parameter int unsigned TASK_SLOTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,      // tick_wrap

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,       // period[15:0], phase_offset[31:16],
                                            // finished_index[34:32], zero fill
    input  wire logic [1:0]  s_tuser,       // command

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,       // task_index[2:0], overrun_total[18:3],
                                            // tick_now[34:19], zero fill
    output logic [2:0]       m_tuser,       // kind
    output logic             m_tlast        // last
);

    import ptd_pkg::*;

    localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int unsigned CMP_W = (CNT_W > 3) ? CNT_W : 3;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TASK_SLOTS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FREAD = 8'b0000_0010,
        S_TDIV  = 8'b0000_0100,
        S_TREAD = 8'b0000_1000,
        S_TMOD  = 8'b0001_0000,
        S_TNEXT = 8'b0010_0000,
        S_TEND  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t                 state_reg, state_next;
    state_t                 ret_reg, ret_next;
    logic [CNT_W-1:0]       task_count_reg, task_count_next;
    logic [VAL_W-1:0]       tick_reg, tick_next;
    logic [VAL_W-1:0]       wrap_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [2:0]             fin_reg, fin_next;
    entry_t                 ent_reg, ent_next;

    logic [DIV_W-1:0]       div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]       div_dvd_reg, div_dvd_next;
    logic [DIV_W-1:0]       div_dsr_reg, div_dsr_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [DIV_W:0]         div_sh;
    logic [DIV_W-1:0]       div_rem_step;

    kind_t                  res_kind_reg, res_kind_next;
    logic [2:0]             res_idx_reg, res_idx_next;
    logic [VAL_W-1:0]       res_ovr_reg, res_ovr_next;
    logic                   res_last_reg, res_last_next;

    logic                   m_valid_reg, m_valid_next;
    logic [2:0]             m_kind_reg, m_kind_next;
    logic [2:0]             m_idx_reg, m_idx_next;
    logic [VAL_W-1:0]       m_ovr_reg, m_ovr_next;
    logic [VAL_W-1:0]       m_tick_reg, m_tick_next;
    logic                   m_last_reg, m_last_next;

    entry_t                 task_mem [TASK_SLOTS];
    entry_t                 mem_rd_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;
    entry_t                 mem_wd;
    logic [IDX_W-1:0]       mem_ra;

    logic                   s_acc;
    logic                   out_free;
    logic [DIV_W-1:0]       wrap_mod;
    logic [VAL_W-1:0]       in_period;
    logic [VAL_W-1:0]       in_offset;
    logic [2:0]             in_fin;
    logic                   add_ok;
    logic                   add_commit;
    logic                   fin_hit;
    logic [CNT_W-1:0]       idx_inc;
    logic [VAL_W-1:0]       ovr_inc;
    logic                   due;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign in_period = s_tdata[15:0];
    assign in_offset = s_tdata[31:16];
    assign in_fin    = s_tdata[34:32];

    assign wrap_mod  = (wrap_reg == '0) ? {1'b1, {VAL_W{1'b0}}} : {1'b0, wrap_reg};
    assign add_ok    = (task_count_reg < SLOTS_C) && (in_period != '0)
                       && ({1'b0, in_period} < wrap_mod) && ({1'b0, in_offset} < wrap_mod);
    assign add_commit = s_acc && (s_tuser == CMD_ADD) && add_ok;
    assign fin_hit   = CMP_W'(in_fin) < CMP_W'(task_count_reg);
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign ovr_inc   = (ent_reg.overrun != OVR_MAX) ? ent_reg.overrun + VAL_W'(1)
                                                    : ent_reg.overrun;
    assign due       = (div_rem_reg == '0) && (ent_reg.period != '0);

    // bit-serial restoring remainder
    assign div_sh       = {div_rem_reg, div_dvd_reg[DIV_W-1]};
    assign div_rem_step = (div_sh >= {1'b0, div_dsr_reg})
                          ? DIV_W'(div_sh - {1'b0, div_dsr_reg})
                          : div_sh[DIV_W-1:0];

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        task_count_next = task_count_reg;
        tick_next       = tick_reg;
        idx_next        = idx_reg;
        fin_next        = fin_reg;
        ent_next        = ent_reg;
        div_rem_next    = div_rem_reg;
        div_dvd_next    = div_dvd_reg;
        div_dsr_next    = div_dsr_reg;
        div_cnt_next    = div_cnt_reg;
        res_kind_next   = res_kind_reg;
        res_idx_next    = res_idx_reg;
        res_ovr_next    = res_ovr_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_kind_next     = m_kind_reg;
        m_idx_next      = m_idx_reg;
        m_ovr_next      = m_ovr_reg;
        m_tick_next     = m_tick_reg;
        m_last_next     = m_last_reg;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = ent_reg;
        mem_ra          = idx_reg;

        if ((state_reg == S_TDIV || state_reg == S_TMOD) && div_cnt_reg != '0) begin
            div_rem_next = div_rem_step;
            div_dvd_next = {div_dvd_reg[DIV_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_tuser)
                        CMD_ADD: begin
                            res_ovr_next  = '0;
                            res_last_next = 1'b1;
                            ret_next      = S_IDLE;
                            state_next    = S_EMIT;
                            if (add_ok) begin
                                mem_we          = 1'b1;
                                mem_wa          = IDX_W'(task_count_reg);
                                mem_wd          = '{period: in_period, offset: in_offset,
                                                    overrun: '0, running: 1'b0};
                                task_count_next = task_count_reg + CNT_W'(1);
                                res_kind_next   = K_ADD_OK;
                                res_idx_next    = 3'(task_count_reg);
                            end else begin
                                res_kind_next   = K_ADD_REJ;
                                res_idx_next    = '0;
                            end
                        end
                        CMD_TICK: begin
                            div_rem_next = '0;
                            div_dvd_next = {1'b0, tick_reg} + DIV_W'(1);
                            div_dsr_next = wrap_mod;
                            div_cnt_next = DIV_STEPS;
                            state_next   = S_TDIV;
                        end
                        CMD_FINISH: begin
                            fin_next = in_fin;
                            if (fin_hit) begin
                                mem_ra     = IDX_W'(in_fin);
                                state_next = S_FREAD;
                            end else begin
                                res_kind_next = K_FINISH;
                                res_idx_next  = in_fin;
                                res_ovr_next  = '0;
                                res_last_next = 1'b1;
                                ret_next      = S_IDLE;
                                state_next    = S_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FREAD: begin
                mem_we        = 1'b1;
                mem_wa        = IDX_W'(fin_reg);
                mem_wd        = mem_rd_reg;
                mem_wd.running = 1'b0;
                res_kind_next = K_FINISH;
                res_idx_next  = fin_reg;
                res_ovr_next  = mem_rd_reg.overrun;
                res_last_next = 1'b1;
                ret_next      = S_IDLE;
                state_next    = S_EMIT;
            end
            S_TDIV: begin
                if (div_cnt_reg == '0) begin
                    tick_next = div_rem_reg[VAL_W-1:0];
                    idx_next  = '0;
                    mem_ra    = '0;
                    if (task_count_reg == '0) begin
                        state_next = S_TEND;
                    end else begin
                        state_next = S_TREAD;
                    end
                end
            end
            S_TREAD: begin
                ent_next     = mem_rd_reg;
                div_rem_next = '0;
                div_dvd_next = {1'b0, tick_reg} + {1'b0, mem_rd_reg.offset};
                div_dsr_next = {1'b0, mem_rd_reg.period};
                div_cnt_next = DIV_STEPS;
                state_next   = S_TMOD;
            end
            S_TMOD: begin
                if (div_cnt_reg == '0) begin
                    res_idx_next  = 3'(idx_reg);
                    res_last_next = 1'b0;
                    if (!due) begin
                        state_next = S_TNEXT;
                    end else if (ent_reg.running) begin
                        mem_we         = 1'b1;
                        mem_wd.overrun = ovr_inc;
                        res_kind_next  = K_OVERRUN;
                        res_ovr_next   = ovr_inc;
                        ret_next       = S_TEND;
                        state_next     = S_EMIT;
                    end else begin
                        mem_we         = 1'b1;
                        mem_wd.running = 1'b1;
                        res_kind_next  = K_DISPATCH;
                        res_ovr_next   = ent_reg.overrun;
                        ret_next       = S_TNEXT;
                        state_next     = S_EMIT;
                    end
                end
            end
            S_TNEXT: begin
                if (idx_inc < task_count_reg) begin
                    idx_next   = IDX_W'(idx_inc);
                    mem_ra     = IDX_W'(idx_inc);
                    state_next = S_TREAD;
                end else begin
                    state_next = S_TEND;
                end
            end
            S_TEND: begin
                res_kind_next = K_TICK_END;
                res_idx_next  = '0;
                res_ovr_next  = '0;
                res_last_next = 1'b1;
                ret_next      = S_IDLE;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = res_kind_reg;
                    m_idx_next   = res_idx_reg;
                    m_ovr_next   = res_ovr_reg;
                    m_tick_next  = tick_reg;
                    m_last_next  = res_last_reg;
                    state_next   = ret_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            task_count_reg <= '0;
            tick_reg       <= '0;
            wrap_reg       <= WRAP_RESET;
            m_valid_reg    <= 1'b0;
            div_cnt_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            task_count_reg <= task_count_next;
            tick_reg       <= tick_next;
            m_valid_reg    <= m_valid_next;
            div_cnt_reg    <= div_cnt_next;
            if (cfg_valid && cfg_ready) begin
                wrap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        fin_reg      <= fin_next;
        ent_reg      <= ent_next;
        div_rem_reg  <= div_rem_next;
        div_dvd_reg  <= div_dvd_next;
        div_dsr_reg  <= div_dsr_next;
        res_kind_reg <= res_kind_next;
        res_idx_reg  <= res_idx_next;
        res_ovr_reg  <= res_ovr_next;
        res_last_reg <= res_last_next;
        m_kind_reg   <= m_kind_next;
        m_idx_reg    <= m_idx_next;
        m_ovr_reg    <= m_ovr_next;
        m_tick_reg   <= m_tick_next;
        m_last_reg   <= m_last_next;
    end

    // task table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            task_mem[mem_wa] <= mem_wd;
        end
        mem_rd_reg <= task_mem[mem_ra];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_tick_reg, m_ovr_reg, m_idx_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `include "periodic_task_dispatcher_core_assert.svh"

    `PTD_ASSERT_NOW(a_mid_word_kind, aclk, aresetn, m_tvalid && !m_tlast, (m_tuser == K_DISPATCH) || (m_tuser == K_OVERRUN), "non-final word is not dispatch or overrun")

    `PTD_ASSERT_NEXT(a_overrun_ends_scan, aclk, aresetn, (state_reg == S_EMIT) && out_free && (res_kind_reg == K_OVERRUN), state_reg == S_TEND, "scan continued after overrun")

    `PTD_ASSERT_NEXT(a_count_only_on_add, aclk, aresetn, !add_commit, $stable(task_count_reg), "task count changed without an accepted add")

endmodule

`default_nettype wire

>>> verif/tb_periodic_task_dispatcher_core.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_dispatcher_core
// Self-checking bench for the periodic task dispatcher. Command words go in
// through a driver fed from a queue. A cycle-free software copy of the
// scheduler predicts every result word, and the monitor checks them in order.
// The tick wrap is reprogrammed between phases while the block is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_periodic_task_dispatcher_core;
    import ptd_pkg::*;

    localparam int unsigned SLOTS = 8;
    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam int unsigned SETTLE_CYCLES = 250;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] period;
        logic [15:0] offset;
        logic [2:0]  fin;
    } cmd_word_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  idx;
        logic [15:0] ovr;
        logic [15:0] tick;
        logic        last;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    periodic_task_dispatcher_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #9_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // scheduler state mirror
    logic [15:0]   wrap_reg = WRAP_RESET;
    int unsigned   task_total = 0;
    int unsigned   tick_count = 0;
    logic [15:0]   period_tbl [SLOTS];
    logic [15:0]   offset_tbl [SLOTS];
    logic          running_tbl [SLOTS];
    logic [15:0]   overrun_tbl [SLOTS];

    cmd_word_t     pending_words [$];
    sched_result_t awaited_results [$];
    cmd_word_t     cur_word = '0;
    bit            word_taken = 1'b0;
    bit            calm = 1'b0;
    int unsigned   send_gap = 0;
    int unsigned   hold_cycles = 0;
    int unsigned   fault_count = 0;

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            running_tbl[i[2:0]] = 1'b0;
            overrun_tbl[i[2:0]] = '0;
            period_tbl[i[2:0]] = '0;
            offset_tbl[i[2:0]] = '0;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic post_result(input kind_t kind, input logic [2:0] idx,
                               input logic [15:0] ovr, input logic last);
        sched_result_t r;
        r.kind = kind;
        r.idx = idx;
        r.ovr = ovr;
        r.tick = tick_count[15:0];
        r.last = last;
        awaited_results.push_back(r);
    endtask

    task automatic advance_schedule(input cmd_word_t w);
        int unsigned modulus;
        int unsigned due;
        modulus = (wrap_reg == '0) ? 32'd65536 : 32'(wrap_reg);
        case (w.cmd)
            CMD_ADD: begin
                if (task_total < SLOTS && w.period != '0 && 32'(w.period) < modulus &&
                    32'(w.offset) < modulus) begin
                    period_tbl[task_total[2:0]] = w.period;
                    offset_tbl[task_total[2:0]] = w.offset;
                    running_tbl[task_total[2:0]] = 1'b0;
                    overrun_tbl[task_total[2:0]] = '0;
                    post_result(K_ADD_OK, task_total[2:0], '0, 1'b1);
                    task_total++;
                end else begin
                    post_result(K_ADD_REJ, '0, '0, 1'b1);
                end
            end
            CMD_TICK: begin
                tick_count = (tick_count + 1) % modulus;
                for (int i = 0; i < task_total; i++) begin
                    due = (tick_count + 32'(offset_tbl[i[2:0]])) % 32'(period_tbl[i[2:0]]);
                    if (due == 0) begin
                        if (running_tbl[i[2:0]]) begin
                            if (overrun_tbl[i[2:0]] != OVR_MAX) overrun_tbl[i[2:0]]++;
                            post_result(K_OVERRUN, i[2:0], overrun_tbl[i[2:0]], 1'b0);
                            break;
                        end
                        running_tbl[i[2:0]] = 1'b1;
                        post_result(K_DISPATCH, i[2:0], overrun_tbl[i[2:0]], 1'b0);
                    end
                end
                post_result(K_TICK_END, '0, '0, 1'b1);
            end
            CMD_FINISH: begin
                if (32'(w.fin) < task_total) begin
                    running_tbl[w.fin] = 1'b0;
                    post_result(K_FINISH, w.fin, overrun_tbl[w.fin], 1'b1);
                end else begin
                    post_result(K_FINISH, w.fin, '0, 1'b1);
                end
            end
            default: ;
        endcase
    endtask

    // check result words first, then predict the word accepted at this edge
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            got.idx = m_tdata[2:0];
            got.ovr = m_tdata[18:3];
            got.tick = m_tdata[34:19];
            got.last = m_tlast;
            if (awaited_results.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected word kind=%0d idx=%0d ovr=%0d tick=%0d last=%0d",
                         $time, got.kind, got.idx, got.ovr, got.tick, got.last);
            end else begin
                want = awaited_results.pop_front();
                if (got.kind !== want.kind || got.idx !== want.idx ||
                    got.ovr !== want.ovr || got.tick !== want.tick ||
                    got.last !== want.last) begin
                    fault_count++;
                    $display("%0t: mismatch exp kind=%0d idx=%0d ovr=%0d tick=%0d last=%0d",
                             $time, want.kind, want.idx, want.ovr, want.tick, want.last);
                    $display("%0t:          got kind=%0d idx=%0d ovr=%0d tick=%0d last=%0d",
                             $time, got.kind, got.idx, got.ovr, got.tick, got.last);
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            advance_schedule(cur_word);
            word_taken = 1'b1;
        end
    end

    // command word driver
    always @(negedge aclk) begin
        logic next_valid;
        next_valid = s_tvalid;
        if (!s_tvalid || word_taken) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_words.size() != 0) begin
                cur_word = pending_words.pop_front();
                s_tdata = {5'b0, cur_word.fin, cur_word.offset, cur_word.period};
                s_tuser = cur_word.cmd;
                next_valid = 1'b1;
                if (!calm) send_gap = pick_gap();
            end
        end
        s_tvalid = next_valid;
        word_taken = 1'b0;
    end

    // result backpressure
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready = 1'b0;
            hold_cycles--;
        end else begin
            m_tready = 1'b1;
            if (!calm) hold_cycles = pick_gap();
        end
    end

    task automatic queue_word(input logic [1:0] cmd, input logic [15:0] period,
                              input logic [15:0] offset, input logic [2:0] fin);
        cmd_word_t w;
        w.cmd = cmd;
        w.period = period;
        w.offset = offset;
        w.fin = fin;
        pending_words.push_back(w);
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned r;
        logic [1:0]  cmd;
        logic [15:0] period;
        logic [15:0] offset;
        logic [2:0]  fin;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            period = 16'($urandom_range(0, 65535));
            offset = 16'($urandom_range(0, 65535));
            fin = 3'($urandom_range(0, 7));
            if (r < 40) begin
                cmd = CMD_TICK;
            end else if (r < 78) begin
                cmd = CMD_FINISH;
                if ($urandom_range(0, 2) == 0) fin = '0;
            end else if (r < 95) begin
                cmd = CMD_ADD;
                if ($urandom_range(0, 1) == 0) begin
                    period = 16'($urandom_range(0, 16));
                    offset = 16'($urandom_range(0, 16));
                end
            end else begin
                cmd = CMD_IGNORED;
            end
            queue_word(cmd, period, offset, fin);
        end
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending_words.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_tick_wrap(input logic [15:0] value);
        @(negedge aclk);
        cfg_data = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        wrap_reg = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table, rejects, dispatch then overrun, finish cases
        queue_word(CMD_FINISH, 16'd0, 16'd0, 3'd7);
        queue_word(CMD_TICK, 16'hFFFF, 16'hFFFF, 3'd7);
        queue_word(CMD_ADD, 16'd0, 16'd5, 3'd0);
        queue_word(CMD_ADD, 16'd1000, 16'd5, 3'd0);
        queue_word(CMD_ADD, 16'd5, 16'd1000, 3'd0);
        queue_word(CMD_ADD, 16'hFFFF, 16'hFFFF, 3'd0);
        queue_word(CMD_ADD, 16'd1, 16'd0, 3'd0);
        queue_word(CMD_TICK, 16'd0, 16'd0, 3'd0);
        queue_word(CMD_TICK, 16'd0, 16'd0, 3'd0);
        queue_word(CMD_FINISH, 16'd0, 16'd0, 3'd0);
        queue_word(CMD_FINISH, 16'd0, 16'd0, 3'd0);
        queue_word(CMD_IGNORED, 16'hFFFF, 16'hFFFF, 3'd7);
        queue_word(CMD_ADD, 16'd999, 16'd999, 3'd0);
        queue_word(CMD_ADD, 16'd2, 16'd1, 3'd0);
        queue_word(CMD_ADD, 16'd3, 16'd0, 3'd0);
        queue_word(CMD_ADD, 16'd4, 16'd2, 3'd0);
        queue_word(CMD_ADD, 16'd5, 16'd3, 3'd0);
        queue_word(CMD_FINISH, 16'd0, 16'd0, 3'd0);
        queue_word(CMD_TICK, 16'd0, 16'd0, 3'd0);
        drain();

        // wrap of zero acts as 65536
        set_tick_wrap(16'd0);
        queue_word(CMD_ADD, 16'hFFFF, 16'hFFFF, 3'd0);
        queue_word(CMD_TICK, 16'd0, 16'd0, 3'd0);
        queue_word(CMD_FINISH, 16'd0, 16'd0, 3'd6);
        queue_random(100);
        drain();

        calm = 1'b1;
        set_tick_wrap(16'd1);
        queue_random(30);
        drain();

        calm = 1'b0;
        set_tick_wrap(16'hFFFF);
        queue_random(100);
        drain();

        // lowered wrap pulls the counter back into range
        calm = 1'b1;
        set_tick_wrap(16'd12);
        queue_random(100);
        drain();

        calm = 1'b0;
        set_tick_wrap(16'($urandom_range(2, 200)));
        queue_random(90);
        drain();

        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/ptd_pkg.sv
rtl/periodic_task_dispatcher_core.sv
verif/tb_periodic_task_dispatcher_core.sv
